/* src/ordl_pkg.sv */
// ordl_pkg: shared widths, capacity, operation and status codes
// and the command struct broadcast to the storage cells.
// No dependencies.
`default_nettype none

package ordl_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 9;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // widths wide enough to compare a position against count + 1
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // reduction tree: cells are grouped, one registered level per group
    localparam int GRP_SIZE = 16;
    localparam int GRP_W    = $clog2(GRP_SIZE);
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  pos_idx;
        logic [DATA_W-1:0] elem;
        logic [DATA_W-1:0] key;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* src/ordered_array_list_core.sv */
// ordered_array_list_core: top level of the ordered list; operation
// sequencing, range checks, row of storage cells and result register.
// Depends on ordl_pkg, ordl_cell and ordl_reduce.
//
// Usage:
//   One operation per transfer on the s_ channel (s_op, s_position,
//   s_element); exactly one result per operation on the m_ channel
//   (m_status, m_read_value, m_found_position, m_count).
//   Insert and delete move every slot at or above the position at once in
//   the row of cells on the transfer edge. Get and find then pass through
//   the cell match register and a two-level reduction tree (groups of 16
//   cells, first level registered), then the output register. The block
//   takes one operation at a time and accepts no new one until the result
//   is loaded into the output register.
//   s_ready is high only when no operation is in flight.
//   If the receiver stalls, the result waits in the output register and
//   the next result is held back until it is taken.
//   Reset (aresetn low, synchronous) empties the list and drops any
//   pending result; slot contents are not cleared.
`default_nettype none

module ordered_array_list_core
    import ordl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_op,
    input  wire logic [POS_W-1:0]  s_position,
    input  wire logic [DATA_W-1:0] s_element,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [STAT_W-1:0] m_status,
    output logic      [DATA_W-1:0] m_read_value,
    output logic      [POS_W-1:0]  m_found_position,
    output logic      [POS_W-1:0]  m_count
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_GRP  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    op_t                op_reg;
    status_t            status_reg;
    logic [DATA_W-1:0]  key_reg;
    logic [IDX_W-1:0]   sel_idx_reg;

    logic               m_valid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [DATA_W-1:0]  m_read_value_reg;
    logic [POS_W-1:0]   m_found_position_reg;
    logic [POS_W-1:0]   m_count_reg;

    logic               acc;
    logic               out_load;
    op_t                in_op;
    status_t            in_status;
    logic [CMP_W-1:0]   pos_ext, cnt_ext, pos_m1;
    cell_cmd_t          cmd;

    logic [DATA_W-1:0]   cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    logic [DATA_W-1:0]   red_value;
    logic                red_hit;
    logic [IDX_W-1:0]    red_idx;
    logic [IDX_W:0]      found_pos_full;

    // no transfer while reset is held
    assign s_ready = (state_reg == S_IDLE) && aresetn;
    assign acc     = s_valid && s_ready;
    assign in_op   = op_t'(s_op);
    assign pos_ext = CMP_W'(s_position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);

    // range and capacity checks against the count before the operation
    always_comb begin
        in_status = ST_OK;
        unique case (in_op)
            OP_INSERT: begin
                if ((s_position == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
                    in_status = ST_RANGE;
                end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                    in_status = ST_FULL;
                end
            end
            OP_DELETE, OP_GET: begin
                if ((s_position == '0) || (pos_ext > cnt_ext)) begin
                    in_status = ST_RANGE;
                end
            end
            OP_FIND: in_status = ST_OK;
            default: in_status = ST_OK;
        endcase
    end

    always_comb begin
        cmd.ins     = acc && (in_op == OP_INSERT) && (in_status == ST_OK);
        cmd.del     = acc && (in_op == OP_DELETE) && (in_status == ST_OK);
        cmd.pos_idx = pos_m1[IDX_W-1:0];
        cmd.elem    = s_element;
        cmd.key     = key_reg;
        cmd.count   = count_reg;
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (acc) state_next = S_CMP;
            S_CMP:  state_next = S_GRP;
            S_GRP:  state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_entry[i+1];
        end
        ordl_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .my_idx      (IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (cell_entry[i]),
            .hit         (cell_hit[i])
        );
    end

    ordl_reduce u_reduce (
        .aclk       (aclk),
        .entry_in   (cell_entry),
        .hit_in     (cell_hit),
        .sel_idx    (sel_idx_reg),
        .read_value (red_value),
        .found_hit  (red_hit),
        .found_idx  (red_idx)
    );

    assign found_pos_full = {1'b0, red_idx} + (IDX_W + 1)'(1);

    always_ff @(posedge aclk) begin
        if (acc) begin
            op_reg      <= in_op;
            status_reg  <= in_status;
            key_reg     <= s_element;
            sel_idx_reg <= pos_m1[IDX_W-1:0];
        end
        if (out_load) begin
            m_status_reg         <= status_reg;
            m_read_value_reg     <= ((op_reg == OP_GET) && (status_reg == ST_OK))
                                    ? red_value : '0;
            m_found_position_reg <= ((op_reg == OP_FIND) && red_hit)
                                    ? POS_W'(found_pos_full) : '0;
            m_count_reg          <= POS_W'(count_reg);
        end
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_found_position = m_found_position_reg;
    assign m_count          = m_count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("successful insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.del |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("successful delete did not shrink the list");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_found_position <= m_count)
        else $error("found position beyond entry count");

    a_value_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_value != '0)) |-> m_status == ST_OK)
        else $error("read value returned with error status");
`endif

endmodule

`default_nettype wire

/* src/ordl_cell.sv */
// ordl_cell: one storage slot of the list; shifts with its neighbors
// on insert and delete and registers a match flag against the search key.
// Depends on ordl_pkg.
`default_nettype none

module ordl_cell
    import ordl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [IDX_W-1:0]  my_idx,
    input  wire cell_cmd_t         cmd,
    input  wire logic [DATA_W-1:0] left_entry,
    input  wire logic [DATA_W-1:0] right_entry,
    output logic      [DATA_W-1:0] entry,
    output logic                   hit
);

    logic [DATA_W-1:0] entry_reg, entry_next;
    logic              hit_reg, hit_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (my_idx == cmd.pos_idx) begin
                entry_next = cmd.elem;
            end else if (my_idx > cmd.pos_idx) begin
                entry_next = left_entry;
            end
        end else if (cmd.del && (my_idx >= cmd.pos_idx)) begin
            entry_next = right_entry;
        end
    end

    // only occupied slots may match
    assign hit_next = (entry_reg == cmd.key) && (CNT_W'(my_idx) < cmd.count);

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

/* src/ordl_reduce.sv */
// ordl_reduce: two-level tree over the cells, first level registered; picks the
// first matching slot and the slot addressed by a get.
// Depends on ordl_pkg.
`default_nettype none

module ordl_reduce
    import ordl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [DATA_W-1:0] entry_in [CAPACITY],
    input  wire logic [CAPACITY-1:0] hit_in,
    input  wire logic [IDX_W-1:0]  sel_idx,
    output logic      [DATA_W-1:0] read_value,
    output logic                   found_hit,
    output logic      [IDX_W-1:0]  found_idx
);

    logic [NUM_GRP-1:0] grp_hit_reg, grp_hit_next;
    logic [GRP_W-1:0]   grp_first_reg [NUM_GRP];
    logic [GRP_W-1:0]   grp_first_next [NUM_GRP];
    logic [DATA_W-1:0]  grp_val_reg [NUM_GRP];
    logic [DATA_W-1:0]  grp_val_next [NUM_GRP];

    // first level: per group, lowest hit and the selected entry
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            grp_hit_next[g]   = 1'b0;
            grp_first_next[g] = '0;
            grp_val_next[g]   = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--) begin
                if (g * GRP_SIZE + j < CAPACITY) begin
                    if (hit_in[g * GRP_SIZE + j]) begin
                        grp_hit_next[g]   = 1'b1;
                        grp_first_next[g] = GRP_W'(j);
                    end
                    if (IDX_W'(g * GRP_SIZE + j) == sel_idx) begin
                        grp_val_next[g] = grp_val_next[g] | entry_in[g * GRP_SIZE + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_hit_reg <= grp_hit_next;
        for (int g = 0; g < NUM_GRP; g++) begin
            grp_first_reg[g] <= grp_first_next[g];
            grp_val_reg[g]   <= grp_val_next[g];
        end
    end

    // second level across groups, lowest group wins
    always_comb begin
        read_value = '0;
        found_hit  = 1'b0;
        found_idx  = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            read_value = read_value | grp_val_reg[g];
            if (grp_hit_reg[g]) begin
                found_hit = 1'b1;
                found_idx = IDX_W'(g * GRP_SIZE + int'(grp_first_reg[g]));
            end
        end
    end

endmodule

`default_nettype wire
